[rtl/core/lsu_pkg.sv]
// shared types, constants and codes for the rv32i load/store unit
package lsu_pkg;

    // data memory geometry
    localparam int unsigned MEM_WORDS = 4096;
    localparam int unsigned MEM_BYTES = MEM_WORDS * 4;
    localparam int unsigned ROW_W     = $clog2(MEM_WORDS);
    localparam int unsigned LANES     = 4;

    // command queue geometry
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);

    // operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_STORE = 1'b1;

    // funct3 access codes
    localparam logic [2:0] F3_B  = 3'd0;
    localparam logic [2:0] F3_H  = 3'd1;
    localparam logic [2:0] F3_W  = 3'd2;
    localparam logic [2:0] F3_BU = 3'd4;
    localparam logic [2:0] F3_HU = 3'd5;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_BAD_FUNCT3 = 2'd1,
        STATUS_RANGE     = 2'd2
    } lsu_status_t;

    // request payload
    typedef struct packed {
        logic               op;
        logic [2:0]         funct3;
        logic [31:0]        base_value;
        logic signed [11:0] offset;
        logic [31:0]        store_data;
        logic [4:0]         dest_index;
    } lsu_req_t;

    // result payload
    typedef struct packed {
        logic [31:0] load_data;
        logic        write_enable;
        logic [4:0]  dest_out;
        logic [1:0]  status;
    } lsu_rsp_t;

    // classified command between front and back
    typedef struct packed {
        logic                         is_store;
        logic [2:0]                   funct3;
        lsu_status_t                  status;
        logic [4:0]                   dest;
        logic [1:0]                   lane_shift;
        logic [LANES-1:0]             lane_en;
        logic [LANES-1:0][ROW_W-1:0]  lane_row;
        logic [LANES-1:0][7:0]        lane_wdata;
    } lsu_cmd_t;

endpackage

[rtl/core/rv32i_load_store_unit.sv]
// rv32i load/store unit top level: front end, command queue and back end
// path: queue entry, then access stage registers, then result register
// throughput: one request per cycle unless stalled, set by one port per lane memory
// reset: after rst_n rises the data memory is cleared one row per cycle,
// through all MEM_WORDS rows (4096 as built), with req_stall held high meanwhile
// reset empties the queue and clears the valid flags; results then start empty
module rv32i_load_store_unit
    import lsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  lsu_req_t req,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output lsu_rsp_t rsp
);

    lsu_cmd_t front_cmd;
    lsu_cmd_t head_cmd;
    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     head_valid;
    logic     clearing;

    assign req_stall = q_full || clearing;
    assign q_push    = req_valid && !req_stall;

    // request classification
    lsu_front u_front (
        .req (req),
        .cmd (front_cmd)
    );

    // decoupling queue
    lsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // memory access and result
    lsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (q_pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

[rtl/core/lsu_front.sv]
// front end: address generation, size decode, bounds check and lane split
module lsu_front
    import lsu_pkg::*;
(
    input  lsu_req_t req,
    output lsu_cmd_t cmd
);

    logic [31:0] addr;
    logic [2:0]  size;
    logic [32:0] end_addr;
    logic        in_range;
    logic        access_ok;

    // effective address and access size
    always_comb
    begin
        addr = req.base_value + {{20{req.offset[11]}}, req.offset};
        unique case (req.funct3)
            F3_B:    size = 3'd1;
            F3_H:    size = 3'd2;
            F3_W:    size = 3'd4;
            F3_BU:   size = (req.op == OP_STORE) ? 3'd0 : 3'd1;
            F3_HU:   size = (req.op == OP_STORE) ? 3'd0 : 3'd2;
            default: size = 3'd0;
        endcase
        end_addr  = {1'b0, addr} + 33'(size);
        in_range  = end_addr <= 33'(MEM_BYTES);
        access_ok = (size != 3'd0) && in_range;
    end

    // command fields and per-lane split
    always_comb
    begin
        logic [1:0] rel;
        cmd.is_store   = (req.op == OP_STORE);
        cmd.funct3     = req.funct3;
        cmd.dest       = req.dest_index;
        cmd.lane_shift = addr[1:0];
        if (size == 3'd0)
            cmd.status = STATUS_BAD_FUNCT3;
        else if (!in_range)
            cmd.status = STATUS_RANGE;
        else
            cmd.status = STATUS_OK;
        for (int b = 0; b < LANES; b++)
        begin
            rel = 2'(b) - addr[1:0];
            cmd.lane_en[b]    = access_ok && (3'(rel) < size);
            cmd.lane_row[b]   = addr[ROW_W+1:2] + ROW_W'(2'(b) < addr[1:0]);
            cmd.lane_wdata[b] = 8'(req.store_data >> {rel, 3'b000});
        end
    end

endmodule

[rtl/core/lsu_queue.sv]
// small command queue between the front and back ends
module lsu_queue
    import lsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lsu_cmd_t push_cmd,
    output logic     full,
    input  logic     pop,
    output logic     head_valid,
    output lsu_cmd_t head_cmd
);

    lsu_cmd_t             entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;
    logic [Q_PTR_W:0]     count_next;

    assign full       = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    // occupancy update
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/core/lsu_back.sv]
// back end: byte-lane data memory, clearing pass, load alignment and result register
module lsu_back
    import lsu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    input  lsu_cmd_t cmd,
    output logic     cmd_pop,
    output logic     clearing,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output lsu_rsp_t rsp
);

    logic             clearing_reg;
    logic [ROW_W-1:0] clr_row_reg;

    logic             s1_valid_reg;
    logic             s1_store_reg;
    logic [2:0]       s1_funct3_reg;
    lsu_status_t      s1_status_reg;
    logic [4:0]       s1_dest_reg;
    logic [1:0]       s1_shift_reg;
    logic [7:0]       rd_reg [LANES];

    logic             out_valid_reg;
    lsu_rsp_t         out_reg;
    lsu_rsp_t         out_next;

    logic             s1_advance;
    logic             issue;
    logic [31:0]      raw_word;

    assign clearing   = clearing_reg;
    assign s1_advance = s1_valid_reg && (!out_valid_reg || !rsp_stall);
    assign issue      = cmd_valid && !clearing_reg && (!s1_valid_reg || s1_advance);
    assign cmd_pop    = issue;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_row_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_row_reg <= clr_row_reg + 1'b1;
            if (clr_row_reg == ROW_W'(MEM_WORDS - 1))
                clearing_reg <= 1'b0;
        end
    end

    // one byte-wide memory per lane
    for (genvar b = 0; b < LANES; b++)
    begin : g_lane
        logic [7:0] ram_reg [MEM_WORDS];

        always_ff @(posedge clk)
        begin
            if (clearing_reg)
                ram_reg[clr_row_reg] <= 8'h00;
            else if (issue && cmd.is_store && cmd.lane_en[b])
                ram_reg[cmd.lane_row[b]] <= cmd.lane_wdata[b];
            if (issue && !cmd.is_store)
                rd_reg[b] <= ram_reg[cmd.lane_row[b]];
        end
    end

    // access stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (issue)
            s1_valid_reg <= 1'b1;
        else if (s1_advance)
            s1_valid_reg <= 1'b0;
    end

    // access stage payload
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_store_reg  <= cmd.is_store;
            s1_funct3_reg <= cmd.funct3;
            s1_status_reg <= cmd.status;
            s1_dest_reg   <= cmd.dest;
            s1_shift_reg  <= cmd.lane_shift;
        end
    end

    // rotate lanes into byte order and extend
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            raw_word[8*i +: 8] = rd_reg[2'(i) + s1_shift_reg];
        out_next.dest_out     = s1_dest_reg;
        out_next.status       = s1_status_reg;
        out_next.write_enable = 1'b0;
        out_next.load_data    = 32'h0;
        if (!s1_store_reg && (s1_status_reg == STATUS_OK))
        begin
            out_next.write_enable = 1'b1;
            case (s1_funct3_reg)
                F3_B:    out_next.load_data = {{24{raw_word[7]}}, raw_word[7:0]};
                F3_H:    out_next.load_data = {{16{raw_word[15]}}, raw_word[15:0]};
                F3_W:    out_next.load_data = raw_word;
                F3_BU:   out_next.load_data = {24'h0, raw_word[7:0]};
                F3_HU:   out_next.load_data = {16'h0, raw_word[15:0]};
                default: out_next.load_data = 32'h0;
            endcase
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_advance)
            out_valid_reg <= 1'b1;
        else if (!rsp_stall)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (s1_advance)
            out_reg <= out_next;
    end

endmodule
